### sv/dual_channel_lux_calculator_defines.svh
// Assertion macros used by the lux calculator checker.
`ifndef DUAL_CHANNEL_LUX_CALCULATOR_DEFINES_SVH
`define DUAL_CHANNEL_LUX_CALCULATOR_DEFINES_SVH

// Same-cycle implication, quiet while reset is high.
`define DLC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, quiet while reset is high.
`define DLC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also runs through reset.
`define DLC_ASSERT_RESET(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) else $error(msg);

`endif

### sv/dlc_pkg.sv
// Types, constants and table function shared by the lux calculator.
package dlc_pkg;

   localparam int FULL_W     = 16;
   localparam int IR_W       = 16;
   localparam int LUX_W      = 20;
   localparam int INTEG_W    = 10;
   localparam int GAIN_W     = 14;
   localparam int CSR_DATA_W = 14;
   localparam int CSR_IDX_W  = 1;
   localparam int CPL_W      = INTEG_W + GAIN_W;

   localparam int POWER_TABLE_ENTRIES_DEF = 256;
   localparam int DIV_STEP_BITS           = 2;

   // Ratio is Q1.16; only the first band reads it, where it stays at or below 0.5.
   localparam int RATIO_FRAC = 16;
   localparam int RATIO_Q_W  = 17;

   localparam int POW_W      = 24;
   localparam int COEF_W     = 20;
   localparam int COEF_FRAC  = 24;
   localparam int PROD_W     = COEF_W + FULL_W;
   localparam int NUM_W      = PROD_W + 1;
   localparam int NUMU_W     = PROD_W;
   localparam int FP_W       = FULL_W + POW_W;
   localparam int TERM_PW    = FP_W + COEF_W;
   localparam int SCALE_W    = 16;
   localparam int SC_PW      = NUMU_W + SCALE_W;
   localparam int XQ_W       = SC_PW - COEF_FRAC;

   localparam logic [SCALE_W-1:0] LUX_SCALE = 16'd40800;
   localparam logic [LUX_W-1:0]   LUX_MAX   = '1;

   localparam logic [INTEG_W-1:0] INTEG_RESET = 10'd300;
   localparam logic [GAIN_W-1:0]  GAIN_RESET  = 14'd25;
   localparam logic [CPL_W-1:0]   CPL_RESET   = 24'd7500;

   localparam logic [CSR_IDX_W-1:0] CSR_INTEG = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN  = 1'd1;

   // Q0.24 formula coefficients
   localparam logic [COEF_W-1:0] C_B1_A = 20'd510027;
   localparam logic [COEF_W-1:0] C_B1_B = 20'd1040187;
   localparam logic [COEF_W-1:0] C_B2_A = 20'd375810;
   localparam logic [COEF_W-1:0] C_B2_B = 20'd520094;
   localparam logic [COEF_W-1:0] C_B3_A = 20'd214748;
   localparam logic [COEF_W-1:0] C_B3_B = 20'd256691;
   localparam logic [COEF_W-1:0] C_B4_A = 20'd24495;
   localparam logic [COEF_W-1:0] C_B4_B = 20'd18790;

   typedef enum logic [2:0] {
      BAND_ZERO = 3'd0,
      BAND_1    = 3'd1,
      BAND_2    = 3'd2,
      BAND_3    = 3'd3,
      BAND_4    = 3'd4,
      BAND_HIGH = 3'd5
   } band_type;

   typedef struct packed {
      logic [FULL_W-1:0] full_count;
      logic [IR_W-1:0]   infrared_count;
   } req_type;

   typedef struct packed {
      logic [LUX_W-1:0] lux_hundredths;
      band_type         band;
      logic             saturated;
   } rsp_type;

   typedef struct packed {
      band_type          band;
      logic [FULL_W-1:0] full_count;
      logic [IR_W-1:0]   infrared_count;
   } cls_type;

   typedef struct packed {
      logic [XQ_W-1:0] scaled;
      band_type        band;
      logic            pos;
   } fml_type;

   typedef struct packed {
      band_type band;
      logic     pos;
      logic     sat;
   } lux_side_type;

   // Elaboration only: Q0.24 of r^1.4 for a Q0.32 ratio, via a bitwise fifth-root search.
   function automatic logic [POW_W-1:0] pow_entry(input logic [63:0] r32);
      logic [63:0] s;
      logic [63:0] c;
      logic [63:0] p;
      logic [63:0] t;
      s = '0;
      for (int b = 31; b >= 0; b--) begin
         c = s | (64'd1 << b);
         p = c;
         for (int k = 0; k < 4; k++) begin
            p = (p * c) >> 32;
         end
         if (p <= r32) begin
            s = c;
         end
      end
      t = (r32 * s) >> 32;
      t = (t * s) >> 32;
      return POW_W'(t >> 8);
   endfunction

endpackage

### sv/dlc_div_pipe.sv
// Pipelined restoring divider with a sideband that travels with each transaction.
module dlc_div_pipe import dlc_pkg::*; #(
   parameter int DVD_W     = 32,
   parameter int DVS_W     = 16,
   parameter int Q_W       = 17,
   parameter int STEP_BITS = DIV_STEP_BITS,
   parameter int SIDE_W    = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [DVD_W-1:0]  in_dividend,
   input  logic [DVS_W-1:0]  in_divisor,
   input  logic [SIDE_W-1:0] in_side,
   output logic              in_ready,
   output logic              out_valid,
   output logic [Q_W-1:0]    out_quot,
   output logic [SIDE_W-1:0] out_side,
   input  logic              out_ready
);

   localparam int NSTG = (Q_W + STEP_BITS - 1) / STEP_BITS;

   logic              vld_ff  [NSTG];
   logic [DVS_W-1:0]  rem_ff  [NSTG];
   logic [Q_W-1:0]    lq_ff   [NSTG];
   logic [DVS_W-1:0]  dvs_ff  [NSTG];
   logic [SIDE_W-1:0] side_ff [NSTG];

   logic              vld_src  [NSTG];
   logic [DVS_W-1:0]  rem_src  [NSTG];
   logic [Q_W-1:0]    lq_src   [NSTG];
   logic [DVS_W-1:0]  dvs_src  [NSTG];
   logic [SIDE_W-1:0] side_src [NSTG];
   logic              stg_rdy  [NSTG];
   logic              nxt_rdy  [NSTG];

   for (genvar s = 0; s < NSTG; s++) begin : g_stg
      logic [DVS_W-1:0] rem_in;
      logic [Q_W-1:0]   lq_in;

      if (s == 0) begin : g_head
         // Upper dividend bits seed the remainder; lower bits shift in one per step.
         assign vld_src[s]  = in_valid;
         assign rem_src[s]  = DVS_W'(in_dividend >> Q_W);
         assign lq_src[s]   = in_dividend[Q_W-1:0];
         assign dvs_src[s]  = in_divisor;
         assign side_src[s] = in_side;
      end else begin : g_body
         assign vld_src[s]  = vld_ff[s-1];
         assign rem_src[s]  = rem_ff[s-1];
         assign lq_src[s]   = lq_ff[s-1];
         assign dvs_src[s]  = dvs_ff[s-1];
         assign side_src[s] = side_ff[s-1];
      end

      if (s == NSTG - 1) begin : g_last
         assign nxt_rdy[s] = out_ready;
      end else begin : g_mid
         assign nxt_rdy[s] = stg_rdy[s+1];
      end

      assign stg_rdy[s] = !vld_ff[s] || nxt_rdy[s];

      always_comb begin
         logic [DVS_W:0] trial;
         trial  = '0;
         rem_in = rem_src[s];
         lq_in  = lq_src[s];
         for (int k = 0; k < STEP_BITS; k++) begin
            if (s * STEP_BITS + k < Q_W) begin
               trial = {rem_in, lq_in[Q_W-1]};
               if (trial >= {1'b0, dvs_src[s]}) begin
                  rem_in = DVS_W'(trial - {1'b0, dvs_src[s]});
                  lq_in  = {lq_in[Q_W-2:0], 1'b1};
               end else begin
                  rem_in = DVS_W'(trial);
                  lq_in  = {lq_in[Q_W-2:0], 1'b0};
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (stg_rdy[s]) begin
            vld_ff[s] <= vld_src[s];
         end
      end

      always_ff @(posedge clock) begin
         if (stg_rdy[s]) begin
            rem_ff[s]  <= rem_in;
            lq_ff[s]   <= lq_in;
            dvs_ff[s]  <= dvs_src[s];
            side_ff[s] <= side_src[s];
         end
      end
   end

   assign in_ready  = stg_rdy[0];
   assign out_valid = vld_ff[NSTG-1];
   assign out_quot  = lq_ff[NSTG-1];
   assign out_side  = side_ff[NSTG-1];

endmodule

### sv/dlc_classify.sv
// Entry stage: picks the ratio band from exact count comparisons.
module dlc_classify import dlc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  req_type in_data,
   output logic    in_ready,
   output logic    out_valid,
   output cls_type out_data,
   input  logic    out_ready
);

   logic     valid_ff;
   cls_type  data_ff;
   band_type band_in;

   logic [22:0] ir_x100;
   logic [22:0] f_x61;
   logic [18:0] ir_x5;
   logic [18:0] f_x4;
   logic [19:0] ir_x10;
   logic [19:0] f_x13;

   assign ir_x100 = 23'(in_data.infrared_count) * 23'd100;
   assign f_x61   = 23'(in_data.full_count) * 23'd61;
   assign ir_x5   = 19'(in_data.infrared_count) * 19'd5;
   assign f_x4    = 19'(in_data.full_count) << 2;
   assign ir_x10  = 20'(in_data.infrared_count) * 20'd10;
   assign f_x13   = 20'(in_data.full_count) * 20'd13;

   always_comb begin
      if (in_data.full_count == '0) begin
         band_in = BAND_ZERO;
      end else if ({1'b0, in_data.infrared_count} << 1 <= {1'b0, in_data.full_count}) begin
         band_in = BAND_1;
      end else if (ir_x100 <= f_x61) begin
         band_in = BAND_2;
      end else if (ir_x5 <= f_x4) begin
         band_in = BAND_3;
      end else if (ir_x10 <= f_x13) begin
         band_in = BAND_4;
      end else begin
         band_in = BAND_HIGH;
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         data_ff.band           <= band_in;
         data_ff.full_count     <= in_data.full_count;
         data_ff.infrared_count <= in_data.infrared_count;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

### sv/dlc_formula.sv
// Six-stage datapath: table index, power lookup, band formula and lux scaling.
module dlc_formula import dlc_pkg::*; #(
   parameter int POWER_TABLE_ENTRIES = POWER_TABLE_ENTRIES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [RATIO_Q_W-1:0] in_ratio,
   input  cls_type              in_cls,
   output logic                 in_ready,
   output logic                 out_valid,
   output fml_type              out_data,
   input  logic                 out_ready
);

   localparam int IDX_W      = $clog2(POWER_TABLE_ENTRIES);
   localparam int IDX_MUL    = 2 * (POWER_TABLE_ENTRIES - 1);
   localparam int IDX_PW     = RATIO_Q_W + $clog2(IDX_MUL + 1) + 1;
   localparam logic [63:0] DEN = 64'(IDX_MUL);

   // Constant power table, one entry per index step of 0.5/(N-1)
   logic [POW_W-1:0] pow_rom [POWER_TABLE_ENTRIES];

   for (genvar g = 0; g < POWER_TABLE_ENTRIES; g++) begin : g_rom
      localparam logic [63:0]      R32   = (64'(g) << 32) / DEN;
      localparam logic [POW_W-1:0] ENTRY = pow_entry(R32);
      assign pow_rom[g] = ENTRY;
   end

   // Stage 1: index and coefficient select
   logic              s1_v_ff;
   logic [IDX_W-1:0]  s1_idx_ff;
   logic [COEF_W-1:0] s1_ca_ff;
   logic [COEF_W-1:0] s1_cb_ff;
   logic [FULL_W-1:0] s1_f_ff;
   logic [IR_W-1:0]   s1_i_ff;
   band_type          s1_band_ff;
   // Stage 2: lookup and linear products
   logic              s2_v_ff;
   logic [POW_W-1:0]  s2_pow_ff;
   logic [PROD_W-1:0] s2_pa_ff;
   logic [PROD_W-1:0] s2_pb_ff;
   logic [FULL_W-1:0] s2_f_ff;
   band_type          s2_band_ff;
   // Stage 3: count times power, linear difference
   logic              s3_v_ff;
   logic [FP_W-1:0]   s3_fp_ff;
   logic [PROD_W-1:0] s3_pa_ff;
   logic signed [NUM_W-1:0] s3_lin_ff;
   band_type          s3_band_ff;
   // Stage 4: power term
   logic              s4_v_ff;
   logic [PROD_W-1:0] s4_term_ff;
   logic [PROD_W-1:0] s4_pa_ff;
   logic signed [NUM_W-1:0] s4_lin_ff;
   band_type          s4_band_ff;
   // Stage 5: numerator and sign
   logic              s5_v_ff;
   logic [NUMU_W-1:0] s5_numu_ff;
   logic              s5_pos_ff;
   band_type          s5_band_ff;
   // Stage 6: lux scaling
   logic              s6_v_ff;
   fml_type           s6_data_ff;

   logic s1_rdy, s2_rdy, s3_rdy, s4_rdy, s5_rdy, s6_rdy;

   assign s6_rdy   = !s6_v_ff || out_ready;
   assign s5_rdy   = !s5_v_ff || s6_rdy;
   assign s4_rdy   = !s4_v_ff || s5_rdy;
   assign s3_rdy   = !s3_v_ff || s4_rdy;
   assign s2_rdy   = !s2_v_ff || s3_rdy;
   assign s1_rdy   = !s1_v_ff || s2_rdy;
   assign in_ready = s1_rdy;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
         s5_v_ff <= 1'b0;
         s6_v_ff <= 1'b0;
      end else begin
         if (s1_rdy) s1_v_ff <= in_valid;
         if (s2_rdy) s2_v_ff <= s1_v_ff;
         if (s3_rdy) s3_v_ff <= s2_v_ff;
         if (s4_rdy) s4_v_ff <= s3_v_ff;
         if (s5_rdy) s5_v_ff <= s4_v_ff;
         if (s6_rdy) s6_v_ff <= s5_v_ff;
      end
   end

   // Stage 1
   logic [IDX_PW-1:0] idx_prod;
   logic [IDX_PW-1:0] idx_rnd;
   logic [IDX_W-1:0]  idx_in;
   logic [COEF_W-1:0] ca_in;
   logic [COEF_W-1:0] cb_in;

   assign idx_prod = IDX_PW'(in_ratio) * IDX_PW'(IDX_MUL) + IDX_PW'(32768);
   assign idx_rnd  = idx_prod >> RATIO_FRAC;

   always_comb begin
      if (idx_rnd > IDX_PW'(POWER_TABLE_ENTRIES - 1)) begin
         idx_in = IDX_W'(POWER_TABLE_ENTRIES - 1);
      end else begin
         idx_in = idx_rnd[IDX_W-1:0];
      end
   end

   always_comb begin
      case (in_cls.band)
         BAND_1: begin
            ca_in = C_B1_A;
            cb_in = '0;
         end
         BAND_2: begin
            ca_in = C_B2_A;
            cb_in = C_B2_B;
         end
         BAND_3: begin
            ca_in = C_B3_A;
            cb_in = C_B3_B;
         end
         BAND_4: begin
            ca_in = C_B4_A;
            cb_in = C_B4_B;
         end
         default: begin
            ca_in = '0;
            cb_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (s1_rdy) begin
         s1_idx_ff  <= idx_in;
         s1_ca_ff   <= ca_in;
         s1_cb_ff   <= cb_in;
         s1_f_ff    <= in_cls.full_count;
         s1_i_ff    <= in_cls.infrared_count;
         s1_band_ff <= in_cls.band;
      end
   end

   // Stage 2
   always_ff @(posedge clock) begin
      if (s2_rdy) begin
         s2_pow_ff  <= pow_rom[s1_idx_ff];
         s2_pa_ff   <= PROD_W'(s1_ca_ff) * PROD_W'(s1_f_ff);
         s2_pb_ff   <= PROD_W'(s1_cb_ff) * PROD_W'(s1_i_ff);
         s2_f_ff    <= s1_f_ff;
         s2_band_ff <= s1_band_ff;
      end
   end

   // Stage 3
   always_ff @(posedge clock) begin
      if (s3_rdy) begin
         s3_fp_ff   <= FP_W'(s2_f_ff) * FP_W'(s2_pow_ff);
         s3_pa_ff   <= s2_pa_ff;
         s3_lin_ff  <= $signed({1'b0, s2_pa_ff}) - $signed({1'b0, s2_pb_ff});
         s3_band_ff <= s2_band_ff;
      end
   end

   // Stage 4
   logic [TERM_PW-1:0] term_prod;

   assign term_prod = TERM_PW'(s3_fp_ff) * TERM_PW'(C_B1_B);

   always_ff @(posedge clock) begin
      if (s4_rdy) begin
         s4_term_ff <= PROD_W'(term_prod >> COEF_FRAC);
         s4_pa_ff   <= s3_pa_ff;
         s4_lin_ff  <= s3_lin_ff;
         s4_band_ff <= s3_band_ff;
      end
   end

   // Stage 5
   logic signed [NUM_W-1:0] num_in;

   always_comb begin
      case (s4_band_ff)
         BAND_1:  num_in = $signed({1'b0, s4_pa_ff}) - $signed({1'b0, s4_term_ff});
         BAND_2:  num_in = s4_lin_ff;
         BAND_3:  num_in = s4_lin_ff;
         BAND_4:  num_in = s4_lin_ff;
         default: num_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (s5_rdy) begin
         s5_numu_ff <= num_in[NUMU_W-1:0];
         s5_pos_ff  <= !num_in[NUM_W-1] && (num_in != '0);
         s5_band_ff <= s4_band_ff;
      end
   end

   // Stage 6: drop the Q.24 fraction after the hundredths scale
   logic [SC_PW-1:0] sc_prod;

   assign sc_prod = SC_PW'(s5_numu_ff) * SC_PW'(LUX_SCALE);

   always_ff @(posedge clock) begin
      if (s6_rdy) begin
         s6_data_ff.scaled <= XQ_W'(sc_prod >> COEF_FRAC);
         s6_data_ff.band   <= s5_band_ff;
         s6_data_ff.pos    <= s5_pos_ff;
      end
   end

   assign out_valid = s6_v_ff;
   assign out_data  = s6_data_ff;

endmodule

### sv/dual_channel_lux_calculator.sv
// Lux calculator top level: two-channel counts in, lux in hundredths and band out.
// Path from an accepted request to the response: the entry register, the ratio divider
// (9 stages), the formula datapath (6), the lux divider (10) and the output register.
// Throughput: one request per cycle when not stalled; any bubble takes a request under stall.
// Reset: clears every valid bit and sets integration to 300 ms and gain to 25.
module dual_channel_lux_calculator import dlc_pkg::*; #(
   parameter int POWER_TABLE_ENTRIES = POWER_TABLE_ENTRIES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [INTEG_W-1:0] integ_ff;
   logic [GAIN_W-1:0]  gain_ff;
   logic [CPL_W-1:0]   cpl_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff <= INTEG_RESET;
         gain_ff  <= GAIN_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_INTEG: integ_ff <= csr_wdata[INTEG_W-1:0];
            CSR_GAIN:  gain_ff  <= csr_wdata[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   // Counts per lux times 408, registered from the integration and gain registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cpl_ff <= CPL_RESET;
      end else begin
         cpl_ff <= CPL_W'(integ_ff) * CPL_W'(gain_ff);
      end
   end

   logic    cls_rdy;
   logic    cls_vld;
   cls_type cls_data;

   logic                 rdiv_rdy;
   logic                 rdiv_vld;
   logic [RATIO_Q_W-1:0] ratio;
   cls_type              rdiv_cls;
   logic                 fml_rdy;

   dlc_classify u_classify (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .in_ready  (cls_rdy),
      .out_valid (cls_vld),
      .out_data  (cls_data),
      .out_ready (rdiv_rdy)
   );

   assign req_stall = !cls_rdy;

   dlc_div_pipe #(
      .DVD_W     (IR_W + RATIO_FRAC),
      .DVS_W     (FULL_W),
      .Q_W       (RATIO_Q_W),
      .STEP_BITS (DIV_STEP_BITS),
      .SIDE_W    ($bits(cls_type))
   ) u_ratio_div (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (cls_vld),
      .in_dividend ({cls_data.infrared_count, {RATIO_FRAC{1'b0}}}),
      .in_divisor  (cls_data.full_count),
      .in_side     (cls_data),
      .in_ready    (rdiv_rdy),
      .out_valid   (rdiv_vld),
      .out_quot    (ratio),
      .out_side    (rdiv_cls),
      .out_ready   (fml_rdy)
   );

   logic    fml_vld;
   fml_type fml_data;
   logic    ldiv_rdy;

   dlc_formula #(
      .POWER_TABLE_ENTRIES (POWER_TABLE_ENTRIES)
   ) u_formula (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rdiv_vld),
      .in_ratio  (ratio),
      .in_cls    (rdiv_cls),
      .in_ready  (fml_rdy),
      .out_valid (fml_vld),
      .out_data  (fml_data),
      .out_ready (ldiv_rdy)
   );

   // Quotient reaches 2^20 exactly when the scaled value's top bits reach the divisor.
   lux_side_type ldiv_side_in;
   lux_side_type ldiv_side;
   logic         ldiv_vld;
   logic [LUX_W-1:0] lux_quot;
   logic         out_rdy;

   assign ldiv_side_in.band = fml_data.band;
   assign ldiv_side_in.pos  = fml_data.pos;
   assign ldiv_side_in.sat  = fml_data.pos && (CPL_W'(fml_data.scaled >> LUX_W) >= cpl_ff);

   dlc_div_pipe #(
      .DVD_W     (XQ_W),
      .DVS_W     (CPL_W),
      .Q_W       (LUX_W),
      .STEP_BITS (DIV_STEP_BITS),
      .SIDE_W    ($bits(lux_side_type))
   ) u_lux_div (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (fml_vld),
      .in_dividend (fml_data.scaled),
      .in_divisor  (cpl_ff),
      .in_side     (ldiv_side_in),
      .in_ready    (ldiv_rdy),
      .out_valid   (ldiv_vld),
      .out_quot    (lux_quot),
      .out_side    (ldiv_side),
      .out_ready   (out_rdy)
   );

   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;
   rsp_type rsp_data_in;

   always_comb begin
      rsp_data_in.band      = ldiv_side.band;
      rsp_data_in.saturated = ldiv_side.pos && ldiv_side.sat;
      if (!ldiv_side.pos) begin
         rsp_data_in.lux_hundredths = '0;
      end else if (ldiv_side.sat) begin
         rsp_data_in.lux_hundredths = LUX_MAX;
      end else begin
         rsp_data_in.lux_hundredths = lux_quot;
      end
   end

   assign out_rdy = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_rdy) begin
         rsp_valid_ff <= ldiv_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (out_rdy) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### sv/dlc_checker.sv
// Port-level checks for the lux calculator, bound to the top level.
`include "dual_channel_lux_calculator_defines.svh"

module dlc_checker import dlc_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   `DLC_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled response changed")

   `DLC_ASSERT_NOW(a_sat_max, rsp_valid && rsp_data.saturated, rsp_data.lux_hundredths == LUX_MAX, "saturated response below maximum")

   `DLC_ASSERT_NOW(a_no_formula_zero, rsp_valid && (rsp_data.band == BAND_ZERO || rsp_data.band == BAND_HIGH), rsp_data.lux_hundredths == '0 && !rsp_data.saturated, "band without formula gave nonzero lux")

   `DLC_ASSERT_RESET(a_reset_idle, reset, !rsp_valid, "response valid after reset")

endmodule

bind dual_channel_lux_calculator dlc_checker u_dlc_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

### dv/testbench.sv
// Self-checking testbench for the dual-channel lux calculator: stimulus, prediction and checks.
module testbench;
   import dlc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_N        = POWER_TABLE_ENTRIES_DEF;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int TAIL_CYCLES    = 40;
   localparam int unsigned INTEG_AT_RESET = 300;
   localparam int unsigned GAIN_AT_RESET  = 25;

   // Q0.24 formula coefficients
   localparam logic [63:0] K_B1_A = 64'd510027;
   localparam logic [63:0] K_B1_B = 64'd1040187;
   localparam logic [63:0] K_B2_A = 64'd375810;
   localparam logic [63:0] K_B2_B = 64'd520094;
   localparam logic [63:0] K_B3_A = 64'd214748;
   localparam logic [63:0] K_B3_B = 64'd256691;
   localparam logic [63:0] K_B4_A = 64'd24495;
   localparam logic [63:0] K_B4_B = 64'd18790;

   typedef struct packed {
      req_type reading;
      rsp_type lux;
   } lux_expect_type;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_INTEG;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   logic [23:0]    pow14_rom [TABLE_N];
   req_type        readings_q [$];
   lux_expect_type lux_expect_q [$];
   logic [9:0]     integ_mirror;
   logic [13:0]    gain_mirror;
   logic           req_accepted = 1'b0;
   bit             idle_on = 1'b1;
   int             mismatches = 0;
   int             readings_taken = 0;
   int             results_checked = 0;
   int             saturations = 0;
   int             settings_used = 0;
   int             band_hits [6] = '{0, 0, 0, 0, 0, 0};
   int             quiet_cycles = 0;
   int             gap_left = 0;
   int             req_calm = 0;
   int             stall_left = 0;
   int             rsp_calm = 0;

   // Zero counts, band thresholds on both sides, field extremes.
   int unsigned corner_pairs [25][2] = '{
      '{0, 0}, '{0, 65535}, '{1, 0}, '{65535, 0}, '{65535, 65535},
      '{1, 1}, '{2, 1}, '{1, 2}, '{100, 50}, '{100, 51},
      '{100, 61}, '{100, 62}, '{100, 80}, '{100, 81}, '{100, 130},
      '{100, 131}, '{65535, 32767}, '{65535, 32768}, '{50000, 65000}, '{50000, 65001},
      '{65535, 52428}, '{65535, 52429}, '{40000, 24400}, '{40000, 24401}, '{43690, 21845}
   };

   dual_channel_lux_calculator u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Q0.24 of r^1.4 for r = i/(2*(N-1)): fifth root by bitwise search, then r * root^2.
   function automatic logic [23:0] pow14_of(input int unsigned i);
      logic [63:0] r32;
      logic [63:0] root;
      logic [63:0] trial;
      logic [63:0] p;
      logic [63:0] t;
      r32 = (64'(i) << 32) / 64'(2 * (TABLE_N - 1));
      root = '0;
      for (int b = 31; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         p = trial;
         repeat (4) p = (p * trial) >> 32;
         if (p <= r32) begin
            root = trial;
         end
      end
      t = (r32 * root) >> 32;
      t = (t * root) >> 32;
      return 24'(t >> 8);
   endfunction

   function automatic rsp_type predict_lux(input req_type item, input logic [9:0] integ,
                                           input logic [13:0] gain);
      logic [63:0] f;
      logic [63:0] ir;
      logic [63:0] ratio;
      logic [63:0] idx;
      logic [63:0] term;
      logic [63:0] cpl;
      logic [63:0] q;
      longint      num;
      rsp_type     r;
      f = 64'(item.full_count);
      ir = 64'(item.infrared_count);
      num = 0;
      r = '0;
      if (f == 0) begin
         r.band = BAND_ZERO;
      end else if (ir * 2 <= f) begin
         ratio = (ir << 16) / f;
         if (ratio > 64'h3FFFF) begin
            ratio = 64'h3FFFF;
         end
         idx = (ratio * 64'(2 * (TABLE_N - 1)) + 64'd32768) >> 16;
         if (idx > 64'(TABLE_N - 1)) begin
            idx = 64'(TABLE_N - 1);
         end
         term = (K_B1_B * f * 64'(pow14_rom[idx])) >> 24;
         num = longint'(K_B1_A * f) - longint'(term);
         r.band = BAND_1;
      end else if (ir * 100 <= 61 * f) begin
         num = longint'(K_B2_A * f) - longint'(K_B2_B * ir);
         r.band = BAND_2;
      end else if (ir * 5 <= 4 * f) begin
         num = longint'(K_B3_A * f) - longint'(K_B3_B * ir);
         r.band = BAND_3;
      end else if (ir * 10 <= 13 * f) begin
         num = longint'(K_B4_A * f) - longint'(K_B4_B * ir);
         r.band = BAND_4;
      end else begin
         r.band = BAND_HIGH;
      end
      if (num > 0) begin
         cpl = 64'(integ) * 64'(gain);
         if (cpl == 0) begin
            r.lux_hundredths = '1;
            r.saturated = 1'b1;
         end else begin
            q = (64'($unsigned(num)) * 64'd40800) / (cpl << 24);
            if (q > 64'(LUX_MAX)) begin
               r.lux_hundredths = '1;
               r.saturated = 1'b1;
            end else begin
               r.lux_hundredths = q[LUX_W-1:0];
            end
         end
      end
      return r;
   endfunction

   function automatic req_type random_reading();
      req_type     r;
      int unsigned kind;
      int unsigned lim;
      int unsigned n;
      int unsigned d;
      kind = $urandom_range(0, 19);
      r.full_count = 16'($urandom);
      r.infrared_count = 16'($urandom);
      if (kind == 0) begin
         r.full_count = '0;
      end else if (kind > 3) begin
         if (kind <= 5) begin
            r.full_count = 16'($urandom_range(1, 255));
         end else if (r.full_count == 0) begin
            r.full_count = 16'd1;
         end
         if (kind <= 15) begin
            // ratio spread over 0 .. 1.4 so every band is hit
            lim = (32'(r.full_count) * 14) / 10;
            if (lim > 65535) begin
               lim = 65535;
            end
            r.infrared_count = 16'($urandom_range(0, lim));
         end else begin
            // land on a band threshold or one count past it
            case (kind)
               16:      begin n = 1;  d = 2;   end
               17:      begin n = 61; d = 100; end
               18:      begin n = 4;  d = 5;   end
               default: begin n = 13; d = 10;  end
            endcase
            lim = (32'(r.full_count) * n) / d + $urandom_range(0, 1);
            if (lim > 65535) begin
               lim = 65535;
            end
            r.infrared_count = 16'(lim);
         end
      end
      return r;
   endfunction

   // Request driver: hold a stalled transaction, otherwise idle in bursts or present the next one.
   always @(negedge clock) begin
      if (req_calm > 0) begin
         req_calm--;
      end else if ($urandom_range(0, 49) == 0) begin
         req_calm = $urandom_range(20, 80);
      end
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && !req_accepted)) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (idle_on && req_calm == 0 && $urandom_range(0, 9) == 0) begin
            gap_left = $urandom_range(1, 15) - 1;
            req_valid <= 1'b0;
         end else if (readings_q.size() > 0) begin
            req_data <= readings_q.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response back-pressure in random bursts.
   always @(negedge clock) begin
      if (rsp_calm > 0) begin
         rsp_calm--;
      end else if ($urandom_range(0, 49) == 0) begin
         rsp_calm = $urandom_range(20, 80);
      end
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (idle_on && rsp_calm == 0 && $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(1, 15) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Monitor: predict on each accepted request, check each accepted response.
   always @(posedge clock) begin
      lux_expect_type want;
      lux_expect_type pending_want;
      req_accepted <= !reset && req_valid && !req_stall;
      if (reset) begin
         integ_mirror = 10'(INTEG_AT_RESET);
         gain_mirror = 14'(GAIN_AT_RESET);
         quiet_cycles = 0;
      end else begin
         if (req_valid && !req_stall) begin
            pending_want.reading = req_data;
            pending_want.lux = predict_lux(req_data, integ_mirror, gain_mirror);
            lux_expect_q.push_back(pending_want);
            readings_taken++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (lux_expect_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("unexpected response: lux=%0d band=%0d sat=%0b",
                           rsp_data.lux_hundredths, rsp_data.band, rsp_data.saturated);
               end
            end else begin
               want = lux_expect_q.pop_front();
               results_checked++;
               band_hits[want.lux.band]++;
               if (want.lux.saturated) begin
                  saturations++;
               end
               if (rsp_data.lux_hundredths !== want.lux.lux_hundredths ||
                   rsp_data.band !== want.lux.band ||
                   rsp_data.saturated !== want.lux.saturated) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("mismatch: full=%0d ir=%0d exp lux=%0d band=%0d sat=%0b, got lux=%0d band=%0d sat=%0b",
                              want.reading.full_count, want.reading.infrared_count,
                              want.lux.lux_hundredths, want.lux.band, want.lux.saturated,
                              rsp_data.lux_hundredths, rsp_data.band, rsp_data.saturated);
                  end
               end
            end
         end
         if (csr_wr_en) begin
            if (csr_index == CSR_INTEG) begin
               integ_mirror = csr_wdata[9:0];
            end else if (csr_index == CSR_GAIN) begin
               gain_mirror = csr_wdata[13:0];
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                  WATCHDOG_LIMIT, lux_expect_q.size());
         $display("simulation failed");
         $finish;
      end
   end

   // Wait until every queued reading is taken and every result has come back.
   task automatic drain_pipeline();
      while (readings_q.size() > 0 || req_valid || lux_expect_q.size() > 0) begin
         @(posedge clock);
      end
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input int unsigned val);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(val);
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic run_phase(input int unsigned integ, input int unsigned gain,
                            input int unsigned n_random);
      drain_pipeline();
      write_csr(CSR_INTEG, integ);
      write_csr(CSR_GAIN, gain);
      settings_used++;
      repeat (n_random) readings_q.push_back(random_reading());
   endtask

   initial begin
      req_type corner;
      for (int i = 0; i < TABLE_N; i++) begin
         pow14_rom[i] = pow14_of(i);
      end
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      run_phase(INTEG_AT_RESET, GAIN_AT_RESET, 0);
      for (int i = 0; i < 25; i++) begin
         corner.full_count = 16'(corner_pairs[i][0]);
         corner.infrared_count = 16'(corner_pairs[i][1]);
         readings_q.push_back(corner);
      end
      repeat (175) readings_q.push_back(random_reading());

      run_phase(100, 1, 200);
      run_phase(600, 9876, 200);
      run_phase(0, 25, 100);
      run_phase(300, 0, 100);
      run_phase(1023, 16383, 150);
      repeat (3) begin
         run_phase($urandom_range(100, 600), $urandom_range(1, 9876), 150);
      end

      // closing stretch at full rate, no idling on either side
      drain_pipeline();
      idle_on = 1'b0;
      run_phase(408, 1, 150);

      drain_pipeline();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("%0d readings over %0d register settings, %0d results checked, %0d saturated",
               readings_taken, settings_used, results_checked, saturations);
      $display("bands zero/1/2/3/4/high: %0d/%0d/%0d/%0d/%0d/%0d, %0d mismatches",
               band_hits[0], band_hits[1], band_hits[2], band_hits[3], band_hits[4],
               band_hits[5], mismatches);
      if (mismatches == 0 && lux_expect_q.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

### files.f
+incdir+sv
sv/dlc_pkg.sv
sv/dlc_div_pipe.sv
sv/dlc_classify.sv
sv/dlc_formula.sv
sv/dual_channel_lux_calculator.sv
sv/dlc_checker.sv
dv/testbench.sv
